### design/sacr_pkg.sv
// Package for the set-associative cache replacement block.
// Holds sizes, the policy codes, the payload and set row types and the
// priority update functions. Depends on nothing.
`default_nettype none

package sacr_pkg;

  localparam int SETS   = 64;
  localparam int WAYS   = 4;
  localparam int SET_W  = $clog2(SETS);
  localparam int WAY_W  = $clog2(WAYS);
  localparam int LINES  = SETS * WAYS;
  localparam int LINE_W = SET_W + WAY_W;
  localparam int TAG_W  = 20;
  localparam int PRIO_W = 32;
  localparam int TS_W   = 32;
  localparam int CNT_W  = 32;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  // Register index, taken from paddr[2].
  localparam logic REG_POLICY = 1'b0;

  typedef enum logic [1:0] {
    POL_LRU   = 2'd0,
    POL_LIP   = 2'd1,
    POL_LFU   = 2'd2,
    POL_REREF = 2'd3
  } policy_t;

  typedef struct packed {
    logic [TAG_W-1:0] block_address;
    logic [TS_W-1:0]  timestamp;
    logic             is_write;
  } in_item_t;

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] way;
    logic             evicted_valid;
    logic [TAG_W-1:0] evicted_block;
    logic             evicted_dirty;
    logic [CNT_W-1:0] hits_so_far;
    logic [CNT_W-1:0] misses_so_far;
  } out_item_t;

  typedef struct packed {
    logic              dirty;
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
  } line_t;

  typedef line_t [WAYS-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] way;
    logic             ev_valid;
    logic [TAG_W-1:0] ev_block;
    logic             ev_dirty;
  } lk_res_t;

  function automatic logic [PRIO_W-1:0] touch_prio(
    input policy_t pol, input logic [PRIO_W-1:0] p, input logic [TS_W-1:0] ts);
    logic [PRIO_W-1:0] r;
    case (pol)
      POL_LFU: r = (p == {PRIO_W{1'b1}}) ? p : p + PRIO_W'(1);
      POL_REREF: r = '0;
      default: r = ts;
    endcase
    return r;
  endfunction

  function automatic logic [PRIO_W-1:0] install_prio(
    input policy_t pol, input logic [TS_W-1:0] ts);
    logic [PRIO_W-1:0] r;
    case (pol)
      POL_LIP: r = '0;
      POL_LFU: r = PRIO_W'(1);
      POL_REREF: r = PRIO_W'(2);
      default: r = ts;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### design/sacr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; a read and a write to one address in one cycle return old data.
`default_nettype none

module sacr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

### design/sacr_lookup.sv
// Tag compare, victim choice and set row update for one access.
// Uses sacr_pkg types and priority functions; purely combinational.
`default_nettype none

module sacr_lookup (
  input  wire sacr_pkg::in_item_t           item,
  input  wire sacr_pkg::row_t               row,
  input  wire logic [sacr_pkg::WAYS-1:0]    vld,
  input  wire sacr_pkg::policy_t            policy,
  output sacr_pkg::lk_res_t                 res,
  output sacr_pkg::row_t                    new_row
);

  logic [sacr_pkg::WAYS-1:0]  hitv;
  logic [sacr_pkg::WAYS-1:0]  ge3;
  logic                       hit;
  logic                       any_inv;
  logic                       any_ge3;
  logic [sacr_pkg::WAY_W-1:0] hit_way;
  logic [sacr_pkg::WAY_W-1:0] inv_way;
  logic [sacr_pkg::WAY_W-1:0] ge3_way;
  logic [sacr_pkg::WAY_W-1:0] min01, min23, min_way;
  logic [sacr_pkg::WAY_W-1:0] max01, max23, max_way;
  logic [sacr_pkg::WAY_W-1:0] rr_way;
  logic [sacr_pkg::WAY_W-1:0] way;
  logic [1:0]                 maxp;
  logic                       age;

  always_comb begin
    hit_way = '0;
    inv_way = '0;
    ge3_way = '0;
    for (int w = sacr_pkg::WAYS - 1; w >= 0; w--) begin
      hitv[w] = vld[w] && (row[w].tag == item.block_address);
      ge3[w]  = row[w].prio >= sacr_pkg::PRIO_W'(3);
      if (hitv[w]) hit_way = sacr_pkg::WAY_W'(w);
      if (!vld[w]) inv_way = sacr_pkg::WAY_W'(w);
      if (ge3[w])  ge3_way = sacr_pkg::WAY_W'(w);
    end
    hit     = |hitv;
    any_inv = ~&vld;
    any_ge3 = |ge3;

    // First smallest priority; ties keep the lower way.
    min01   = (row[1].prio < row[0].prio) ? 2'd1 : 2'd0;
    min23   = (row[3].prio < row[2].prio) ? 2'd3 : 2'd2;
    min_way = (row[min23].prio < row[min01].prio) ? min23 : min01;

    // First largest priority, only used when every priority is below 3.
    max01   = (row[1].prio[1:0] > row[0].prio[1:0]) ? 2'd1 : 2'd0;
    max23   = (row[3].prio[1:0] > row[2].prio[1:0]) ? 2'd3 : 2'd2;
    max_way = (row[max23].prio[1:0] > row[max01].prio[1:0]) ? max23 : max01;
    maxp    = row[max_way].prio[1:0];

    rr_way = any_ge3 ? ge3_way : max_way;

    if (hit) begin
      way = hit_way;
    end else if (any_inv) begin
      way = inv_way;
    end else if (policy == sacr_pkg::POL_REREF) begin
      way = rr_way;
    end else begin
      way = min_way;
    end

    age = !hit && !any_inv && (policy == sacr_pkg::POL_REREF) && !any_ge3;

    new_row = row;
    if (age) begin
      for (int w = 0; w < sacr_pkg::WAYS; w++) begin
        new_row[w].prio = row[w].prio + sacr_pkg::PRIO_W'(2'd3 - maxp);
      end
    end
    if (hit) begin
      new_row[way].prio = sacr_pkg::touch_prio(policy, row[way].prio, item.timestamp);
    end else begin
      new_row[way].dirty = 1'b0;
      new_row[way].tag   = item.block_address;
      new_row[way].prio  = sacr_pkg::install_prio(policy, item.timestamp);
    end
    if (item.is_write) begin
      new_row[way].dirty = 1'b1;
      new_row[way].prio  = sacr_pkg::touch_prio(policy, new_row[way].prio,
                                                item.timestamp);
    end

    res.hit      = hit;
    res.way      = way;
    res.ev_valid = !hit && vld[way];
    res.ev_block = res.ev_valid ? row[way].tag : '0;
    res.ev_dirty = res.ev_valid && row[way].dirty;
  end

endmodule

`default_nettype wire

### design/set_assoc_cache_replacement.sv
// Top level of the four-way set-associative tag store with selectable
// replacement policy. Uses sacr_pkg, sacr_ram (set rows) and sacr_lookup.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+------------------------------
//   in_      | input     | in_valid / in_stall | in_data   (sacr_pkg::in_item_t)
//   out_     | output    | out_valid/out_stall | out_data  (sacr_pkg::out_item_t)
//   APB      | input     | psel/penable/pready | pwdata/prdata, policy at 0x0
//
// One transaction is accepted every cycle when the result side keeps up.
// A result is registered after its transaction is accepted: the set row RAM
// read and the input register share the accepting edge, and the lookup stage
// writes the output register once the stage advances.
// Reset clears the valid bits, counters and policy; no clearing pass is
// needed because tag, dirty and priority are only used under a set valid
// bit. A stalled output holds the lookup stage, and the input stalls only
// when that stage is full and cannot drain.
`default_nettype none

module set_assoc_cache_replacement (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // Input channel.
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire sacr_pkg::in_item_t           in_data,
  // Result channel.
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output sacr_pkg::out_item_t               out_data,
  // Configuration port.
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [sacr_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [sacr_pkg::DATA_W-1:0]  pwdata,
  output logic      [sacr_pkg::DATA_W-1:0]  prdata,
  output logic                              pready
);

  sacr_pkg::policy_t               policy_r;
  logic [sacr_pkg::LINES-1:0]      line_valid_r, line_valid_nxt;
  logic [sacr_pkg::CNT_W-1:0]      hits_r, hits_nxt;
  logic [sacr_pkg::CNT_W-1:0]      misses_r, misses_nxt;

  logic                            s1_valid_r;
  sacr_pkg::in_item_t              s1_item_r;
  logic                            byp_sel_r;
  sacr_pkg::row_t                  byp_row_r;
  logic                            out_valid_r;
  sacr_pkg::out_item_t             out_data_r;

  logic                            in_accept;
  logic                            s1_adv;
  logic [sacr_pkg::SET_W-1:0]      in_set;
  logic [sacr_pkg::SET_W-1:0]      s1_set;
  logic [sacr_pkg::ROW_W-1:0]      ram_rdata;
  sacr_pkg::row_t                  cur_row;
  sacr_pkg::row_t                  new_row;
  logic [sacr_pkg::WAYS-1:0]       cur_vld;
  sacr_pkg::lk_res_t               lk_res;
  sacr_pkg::out_item_t             result;

  // The configuration register is written on the access phase of an APB write.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == sacr_pkg::REG_POLICY)
                  ? sacr_pkg::DATA_W'(policy_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= sacr_pkg::POL_LRU;
    end else if (psel && penable && pwrite && pready
                 && (paddr[2] == sacr_pkg::REG_POLICY)) begin
      policy_r <= sacr_pkg::policy_t'(pwdata[1:0]);
    end
  end

  // Handshake. The lookup stage drains into the output register whenever
  // that register is empty or is being taken in this cycle.
  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  assign in_set = in_data.block_address[sacr_pkg::SET_W-1:0];
  assign s1_set = s1_item_r.block_address[sacr_pkg::SET_W-1:0];

  // One RAM word holds the dirty bit, tag and priority of all four ways of a
  // set. The row is read when a transaction is accepted and written back when
  // that transaction leaves the lookup stage.
  sacr_ram #(
    .WIDTH (sacr_pkg::ROW_W),
    .DEPTH (sacr_pkg::SETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_set),
    .wdata (new_row),
    .re    (in_accept),
    .raddr (in_set),
    .rdata (ram_rdata)
  );

  // When the transaction in the lookup stage writes the same set that the
  // newly accepted one reads, the RAM returns the old row. The written row
  // is kept aside and used in its place.
  assign cur_row = byp_sel_r ? byp_row_r : sacr_pkg::row_t'(ram_rdata);

  always_comb begin
    for (int w = 0; w < sacr_pkg::WAYS; w++) begin
      cur_vld[w] = line_valid_r[{s1_set, sacr_pkg::WAY_W'(w)}];
    end
  end

  sacr_lookup u_lookup (
    .item    (s1_item_r),
    .row     (cur_row),
    .vld     (cur_vld),
    .policy  (policy_r),
    .res     (lk_res),
    .new_row (new_row)
  );

  // Counters and valid bits advance with the transaction leaving the stage.
  always_comb begin
    hits_nxt       = hits_r;
    misses_nxt     = misses_r;
    line_valid_nxt = line_valid_r;
    if (s1_adv) begin
      if (lk_res.hit) begin
        hits_nxt = hits_r + sacr_pkg::CNT_W'(1);
      end else begin
        misses_nxt = misses_r + sacr_pkg::CNT_W'(1);
      end
      line_valid_nxt[{s1_set, lk_res.way}] = 1'b1;
    end
  end

  always_comb begin
    result.hit           = lk_res.hit;
    result.way           = lk_res.way;
    result.evicted_valid = lk_res.ev_valid;
    result.evicted_block = lk_res.ev_block;
    result.evicted_dirty = lk_res.ev_dirty;
    result.hits_so_far   = hits_nxt;
    result.misses_so_far = misses_nxt;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      byp_sel_r    <= 1'b0;
      line_valid_r <= '0;
      hits_r       <= '0;
      misses_r     <= '0;
    end else begin
      line_valid_r <= line_valid_nxt;
      hits_r       <= hits_nxt;
      misses_r     <= misses_nxt;
      if (in_accept) begin
        s1_valid_r <= 1'b1;
        byp_sel_r  <= s1_adv && (s1_set == in_set);
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_data;
      byp_row_r <= new_row;
    end
    if (s1_adv) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### verif/tb_set_assoc_cache_replacement.sv
// Self-checking testbench for set_assoc_cache_replacement, the four-way tag store.
// Uses sacr_pkg for sizes, policy codes and payload types. It needs only the
// RTL and runs directed and random accesses under all four replacement policies.
module tb_set_assoc_cache_replacement;
  timeunit 1ns;
  timeprecision 1ps;

  import sacr_pkg::*;

  // The policy register is picked by paddr[2]; the other index is unused.
  localparam logic [ADDR_W-1:0] POLICY_ADDR = {REG_POLICY, 2'b00};
  localparam logic [ADDR_W-1:0] UNUSED_ADDR = {~REG_POLICY, 2'b00};
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 244;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  set_assoc_cache_replacement dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow copy of the tag store, the counters and the policy register.
  logic model_valid [LINES];
  logic model_dirty [LINES];
  logic [TAG_W-1:0] model_tag [LINES];
  logic [PRIO_W-1:0] model_prio [LINES];
  logic [CNT_W-1:0] hit_count;
  logic [CNT_W-1:0] miss_count;
  policy_t model_policy;

  // Accesses waiting to be driven, and the results they are expected to give.
  in_item_t pending_items [$];
  out_item_t pending_results [$];

  int sender_idle_pct;
  int recv_idle_pct;
  int items_total;
  int results_seen;
  int fail_count;
  int cfg_writes;
  logic in_took;
  logic [TS_W-1:0] ts_clock;
  out_item_t want;
  policy_t phase_policy [RANDOM_PHASES] = '{POL_LIP, POL_REREF, POL_LRU, POL_LFU,
                                            POL_REREF, POL_LIP, POL_LFU, POL_LRU};

  always #5 clk = ~clk;

  // Priority of a line after it is touched: a hit, or the second update that a
  // write applies. LFU counts up and sticks at the top, RRIP marks the line as
  // near re-reference, LRU and LIP record the access time.
  function automatic logic [PRIO_W-1:0] touched_prio(logic [PRIO_W-1:0] p,
                                                     logic [TS_W-1:0] ts);
    if (model_policy == POL_LFU) begin
      return (p == '1) ? p : p + 1'b1;
    end else if (model_policy == POL_REREF) begin
      return '0;
    end
    return ts;
  endfunction

  // Applies one access to the shadow tag store and returns the result the
  // block must report for it.
  function automatic out_item_t predict_access(in_item_t a);
    int base;
    int victim;
    bit found;
    logic [PRIO_W-1:0] maxp;
    out_item_t r;
    r = '0;
    found = 0;
    victim = -1;
    base = (a.block_address % SETS) * WAYS;
    for (int w = 0; w < WAYS; w++) begin
      if (!found && model_valid[base + w] && model_tag[base + w] == a.block_address) begin
        found = 1;
        victim = w;
      end
    end
    if (found) begin
      hit_count++;
      model_prio[base + victim] = touched_prio(model_prio[base + victim], a.timestamp);
    end else begin
      miss_count++;
      // An empty way is always taken first.
      for (int w = 0; w < WAYS; w++) begin
        if (victim < 0 && !model_valid[base + w]) victim = w;
      end
      if (victim < 0 && model_policy == POL_REREF) begin
        // The first distant line wins; if none, the whole set ages until the
        // first line with the largest value reaches the distant mark.
        for (int w = 0; w < WAYS; w++) begin
          if (victim < 0 && model_prio[base + w] >= 3) victim = w;
        end
        if (victim < 0) begin
          maxp = '0;
          victim = 0;
          for (int w = 0; w < WAYS; w++) begin
            if (model_prio[base + w] > maxp) begin
              maxp = model_prio[base + w];
              victim = w;
            end
          end
          for (int w = 0; w < WAYS; w++) model_prio[base + w] += 3 - maxp;
        end
      end else if (victim < 0) begin
        // First way with the smallest priority, unsigned.
        victim = 0;
        for (int w = 1; w < WAYS; w++) begin
          if (model_prio[base + w] < model_prio[base + victim]) victim = w;
        end
      end
      if (model_valid[base + victim]) begin
        r.evicted_valid = 1'b1;
        r.evicted_block = model_tag[base + victim];
        r.evicted_dirty = model_dirty[base + victim];
      end
      model_valid[base + victim] = 1'b1;
      model_dirty[base + victim] = 1'b0;
      model_tag[base + victim] = a.block_address;
      case (model_policy)
        POL_LIP: model_prio[base + victim] = '0;
        POL_LFU: model_prio[base + victim] = 1;
        POL_REREF: model_prio[base + victim] = 2;
        default: model_prio[base + victim] = a.timestamp;
      endcase
    end
    if (a.is_write) begin
      model_dirty[base + victim] = 1'b1;
      model_prio[base + victim] = touched_prio(model_prio[base + victim], a.timestamp);
    end
    r.hit = found;
    r.way = victim[WAY_W-1:0];
    r.hits_so_far = hit_count;
    r.misses_so_far = miss_count;
    return r;
  endfunction

  // Random access. Most of them hammer a few hot sets with a small pool of tags
  // so that hits, evictions and dirty write-backs are frequent; the rest use
  // any address. Time mostly runs forward, with occasional arbitrary values.
  function automatic in_item_t random_access();
    in_item_t a;
    int pick;
    pick = $urandom_range(99);
    if (pick < 75) begin
      a.block_address = TAG_W'($urandom_range(6) * SETS + $urandom_range(3));
    end else begin
      a.block_address = TAG_W'($urandom);
    end
    pick = $urandom_range(99);
    if (pick < 88) begin
      ts_clock += $urandom_range(4, 1);
      a.timestamp = ts_clock;
    end else if (pick < 92) begin
      a.timestamp = '1;
    end else if (pick < 94) begin
      a.timestamp = '0;
    end else begin
      a.timestamp = $urandom;
    end
    a.is_write = 1'($urandom_range(1));
    return a;
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
    if (actual !== expected) begin
      note_failure($sformatf("%s expected 0x%0h, got 0x%0h", name, expected, actual));
    end
  endtask

  task automatic queue_access(logic [TAG_W-1:0] addr, logic [TS_W-1:0] ts, logic wr);
    in_item_t a;
    a.block_address = addr;
    a.timestamp = ts;
    a.is_write = wr;
    pending_items.push_back(a);
    items_total++;
  endtask

  // Returns once every queued transaction has produced its result, and then
  // waits on so that the two-stage pipeline is certainly empty.
  task automatic wait_drained();
    while (results_seen != items_total) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Register write in a setup and an access phase, then a read-back of the
  // policy register, which must hold whatever the shadow copy holds.
  task automatic apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr[2] == REG_POLICY) model_policy = policy_t'(value[1:0]);
    cfg_writes++;
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    paddr <= POLICY_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== DATA_W'(model_policy)) begin
      note_failure($sformatf("policy read-back expected %0d, got 0x%0h",
                             model_policy, prdata));
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Driver: inputs change on the falling edge. A transaction stays on the bus,
  // unchanged, until the block takes it; only then is the next one offered.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || in_took) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor: both channels are sampled on the rising edge. An accepted input
  // transaction is run through the shadow model at once; an accepted result is
  // checked field by field against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
      if (in_valid && !in_stall) pending_results.push_back(predict_access(in_data));
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          note_failure("result transaction with no access outstanding");
        end else begin
          want = pending_results.pop_front();
          results_seen++;
          check_field("hit", 32'(want.hit), 32'(out_data.hit));
          check_field("way", 32'(want.way), 32'(out_data.way));
          check_field("evicted_valid", 32'(want.evicted_valid),
                      32'(out_data.evicted_valid));
          check_field("evicted_block", 32'(want.evicted_block),
                      32'(out_data.evicted_block));
          check_field("evicted_dirty", 32'(want.evicted_dirty),
                      32'(out_data.evicted_dirty));
          check_field("hits_so_far", want.hits_so_far, out_data.hits_so_far);
          check_field("misses_so_far", want.misses_so_far, out_data.misses_so_far);
        end
      end
    end
  end

  // Stimulus and phase control.
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_took = 1'b0;
    items_total = 0;
    results_seen = 0;
    fail_count = 0;
    cfg_writes = 0;
    ts_clock = '0;
    hit_count = '0;
    miss_count = '0;
    model_policy = POL_LRU;
    for (int i = 0; i < LINES; i++) begin
      model_valid[i] = 1'b0;
      model_dirty[i] = 1'b0;
      model_tag[i] = '1;
      model_prio[i] = '0;
    end
    sender_idle_pct = 30;
    recv_idle_pct = 85;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // LRU straight out of reset. Set 0 fills up with extreme addresses and
    // times, one line is refreshed, and two misses then evict a clean and a
    // dirty line. The top address leaves a line with the largest priority.
    queue_access(20'h00000, 32'h0000_0000, 1'b0);
    queue_access(20'h00040, 32'hFFFF_FFFF, 1'b1);
    queue_access(20'h00080, 32'h0000_0005, 1'b0);
    queue_access(20'hFFFC0, 32'h0000_0007, 1'b1);
    queue_access(20'h00040, 32'h0000_0003, 1'b0);
    queue_access(20'h00100, 32'h0000_0009, 1'b0);
    queue_access(20'h00000, 32'h0000_000A, 1'b1);
    queue_access(20'hFFFFF, 32'hFFFF_FFFF, 1'b1);
    wait_drained();

    // LFU inherits the LRU priorities: a hit on the line at the top of the
    // range must saturate, also with the second update of a write.
    apb_write(POLICY_ADDR, DATA_W'(POL_LFU));
    queue_access(20'hFFFFF, 32'h0000_0000, 1'b0);
    queue_access(20'hFFFFF, 32'h0000_0001, 1'b1);
    queue_access(20'h00140, 32'h0000_0002, 1'b0);
    wait_drained();

    // A write to the unused register index must leave the policy alone.
    apb_write(UNUSED_ADDR, '1);
    apb_write(POLICY_ADDR, DATA_W'(POL_REREF));
    // Set 2: four fresh lines, then a miss that has to age the whole set.
    queue_access(20'h00002, 32'h0000_0010, 1'b0);
    queue_access(20'h00042, 32'h0000_0011, 1'b0);
    queue_access(20'h00082, 32'h0000_0012, 1'b0);
    queue_access(20'h000C2, 32'h0000_0013, 1'b0);
    queue_access(20'h00102, 32'h0000_0014, 1'b0);
    // Set 3: written lines drop to zero, so the aging starts from nothing.
    queue_access(20'h00003, 32'h0000_0015, 1'b1);
    queue_access(20'h00043, 32'h0000_0016, 1'b1);
    queue_access(20'h00083, 32'h0000_0017, 1'b1);
    queue_access(20'h000C3, 32'h0000_0018, 1'b1);
    queue_access(20'h00103, 32'h0000_0019, 1'b0);
    // Set 0 still holds large LRU priorities: the first distant way goes.
    queue_access(20'h00180, 32'h0000_001A, 1'b0);
    wait_drained();

    // LIP installs at the lowest priority and promotes on a hit.
    apb_write(POLICY_ADDR, DATA_W'(POL_LIP));
    queue_access(20'h00005, 32'h0000_0100, 1'b0);
    queue_access(20'h00005, 32'h0000_0101, 1'b0);
    wait_drained();

    // Random phases: the policy changes between phases while the block is
    // idle, and the handshake pressure moves from a slow receiver to a slow
    // sender and finally to full rate on both sides.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph < 3) begin
        sender_idle_pct = 30;
        recv_idle_pct = 85;
      end else if (ph < 6) begin
        sender_idle_pct = 85;
        recv_idle_pct = 30;
      end else begin
        sender_idle_pct = 0;
        recv_idle_pct = 0;
      end
      apb_write(POLICY_ADDR, DATA_W'(phase_policy[ph]));
      repeat (ITEMS_PER_PHASE) begin
        pending_items.push_back(random_access());
        items_total++;
      end
      wait_drained();
    end

    repeat (10) @(negedge clk);
    if (pending_results.size() != 0) begin
      note_failure($sformatf("%0d predicted results never arrived", pending_results.size()));
    end
    $display("Run covered %0d accesses (%0d hits, %0d misses) and %0d register writes",
             results_seen, hit_count, miss_count, cfg_writes);
    $display("across all four replacement policies; %0d check failures.", fail_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a tenth of this time.
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

### set_assoc_cache_replacement.f
design/sacr_pkg.sv
design/sacr_ram.sv
design/sacr_lookup.sv
design/set_assoc_cache_replacement.sv
verif/tb_set_assoc_cache_replacement.sv
